// File: hw/rtl/dac_pkg.sv
// Shared types, codes, constants and calendar helpers for the date add and
// difference core. No dependencies; imported by every module of the block.
package dac_pkg;

  // Stream widths: request and result payloads packed from the lowest bit up.
  localparam int unsigned InTdataW  = 64;
  localparam int unsigned OutTdataW = 40;
  localparam int unsigned StatusW   = 2;

  localparam logic [13:0] YearMax  = 14'd9999;
  localparam logic [3:0]  MonthJan = 4'd1;
  localparam logic [3:0]  MonthFeb = 4'd2;
  localparam logic [3:0]  MonthDec = 4'd12;

  // Largest add count and largest reported difference.
  localparam int unsigned MaxDays   = 32'd65535;
  localparam logic [16:0] DiffLimit = (MaxDays < 32'd65535) ? 17'(MaxDays) : 17'd65535;

  // Divisibility by 25 through the inverse of 25 modulo 2^14.
  localparam logic [13:0] Div25Inv = 14'd7209;
  localparam logic [13:0] Div25Max = 14'd655;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_DIFF = 1'b1
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAP_S,
    S_LEAP_T,
    S_CHECK,
    S_STEP,
    S_LEAP_C,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic    load;
    logic    leap_start;
    logic    leap_target;
    logic    leap_cur;
    logic    step;
    logic    set_status;
    status_e status_code;
    logic    finish;
  } dac_cmd_t;

  typedef struct packed {
    req_e mode;
    logic start_ok;
    logic target_ok;
    logic cnt_ok;
    logic target_before;
    logic step_done;
    logic step_wrap;
    logic step_err;
    logic out_busy;
  } dac_sts_t;

  function automatic logic div_by_25(input logic [13:0] y);
    logic [27:0] p;
    p = 28'(y) * 28'(Div25Inv);
    return p[13:0] <= Div25Max;
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    return (y[1:0] == 2'd0) && (!div_by_25(y) || (y[3:0] == 4'd0));
  endfunction

  // Zero for a month code outside January to December.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
                                   input logic [4:0] d, input logic leap);
    return (y <= YearMax) && (m >= MonthJan) && (m <= MonthDec) &&
           (d != 5'd0) && (d <= month_len(m, leap));
  endfunction

endpackage

// File: hw/rtl/date_add_and_difference_core.sv
// Top level of the date add and difference core: joins the sequencer and the
// datapath. Depends on dac_pkg, dac_ctrl and dac_dpath.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  s_axis   | request   | tdata: dates and count, tuser: req_type
//  m_axis   | result    | tdata: date, difference, leap flag, tuser: status
//
// Sequence: one request at a time; after acceptance the sequencer updates the
// start and target leap flags, runs the checks, walks the months unless a
// check fails, and hands the result to the result register once any earlier
// result has been taken, then returns to idle. The month walk advances one
// month per cycle and pauses at each new year to update the leap flag.
// Reset clears the sequencer and the result valid flag; no clearing pass.
// A new request is taken while an earlier result still waits downstream;
// it finishes only once that result has been taken.
module date_add_and_difference_core import dac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], add_days[38:23],
  // target_year[52:39], target_month[56:53], target_day[61:57], zero[63:62]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // req_type[0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_year[13:0], out_month[17:14], out_day[22:18], day_difference[38:23],
  // start_is_leap[39]
  output logic [OutTdataW-1:0] m_axis_tdata,
  // status[1:0]
  output logic [StatusW-1:0]   m_axis_tuser
);

  dac_cmd_t cmd;
  dac_sts_t sts;

  dac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dac_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  // A result is never handed over while the previous one is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !sts.out_busy)
    else $error("result overwritten while stalled");

  // Error results carry no date and no difference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata[38:0] == 39'd0))
    else $error("error result with payload");

  // The result flag rises only after a finish command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.finish))
    else $error("result valid without finish");

endmodule

// File: hw/rtl/dac_ctrl.sv
// Sequencer of the date add and difference core: accepts a request, runs the
// checks and the month walk, and hands the result over. Depends on dac_pkg.
module dac_ctrl import dac_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dac_sts_t sts_i,
  output dac_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  logic chk_range, chk_order;

  always_comb begin
    chk_range = !sts_i.start_ok ||
                ((sts_i.mode == REQ_ADD) && !sts_i.cnt_ok) ||
                ((sts_i.mode == REQ_DIFF) && !sts_i.target_ok);
    chk_order = (sts_i.mode == REQ_DIFF) && sts_i.target_before;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_LEAP_S;
      end
      S_LEAP_S: state_d = S_LEAP_T;
      S_LEAP_T: state_d = S_CHECK;
      S_CHECK: begin
        if (chk_range || chk_order) state_d = S_DONE;
        else                        state_d = S_STEP;
      end
      S_STEP: begin
        priority if (sts_i.step_err)  state_d = S_DONE;
        else if (sts_i.step_done)     state_d = S_DONE;
        else if (sts_i.step_wrap)     state_d = S_LEAP_C;
        else                          state_d = S_STEP;
      end
      S_LEAP_C: state_d = S_STEP;
      S_DONE: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.status_code = ST_OK;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_LEAP_S: cmd_o.leap_start  = 1'b1;
      S_LEAP_T: cmd_o.leap_target = 1'b1;
      S_CHECK: begin
        cmd_o.set_status  = chk_range || chk_order;
        cmd_o.status_code = chk_range ? ST_RANGE : ST_ORDER;
      end
      S_STEP: begin
        cmd_o.step        = 1'b1;
        cmd_o.set_status  = sts_i.step_err;
        cmd_o.status_code = ST_RANGE;
      end
      S_LEAP_C: cmd_o.leap_cur = 1'b1;
      S_DONE:   cmd_o.finish   = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/dac_dpath.sv
// Datapath of the date add and difference core: date registers, leap unit,
// month walker, difference counter and result register. Depends on dac_pkg.
module dac_dpath import dac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [InTdataW-1:0]  in_data_i,
  input  logic                 in_user_i,
  input  dac_cmd_t             cmd_i,
  output dac_sts_t             sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [OutTdataW-1:0] out_data_o,
  output logic [StatusW-1:0]   out_user_o
);

  req_e        mode_q;
  logic [13:0] y_q, ty_q;
  logic [3:0]  m_q, tm_q;
  logic [4:0]  d_q, td_q;
  logic [15:0] rem_q;
  logic [16:0] diff_q;
  logic        leap_q, tleap_q, sleap_q;
  status_e     status_q;
  logic        out_valid_q;
  logic [OutTdataW-1:0] out_data_q;
  logic [StatusW-1:0]   out_user_q;

  // Leap unit, shared between start, target and running year
  logic [13:0] leap_year;
  logic        leap_w;
  assign leap_year = cmd_i.leap_target ? ty_q : y_q;
  assign leap_w    = is_leap(leap_year);

  // One month of the walk
  logic [4:0]  ml, left;
  logic        fits, same_month, end_of_year;
  logic [5:0]  diff_inc;
  logic [16:0] diff_nxt;

  always_comb begin
    ml          = month_len(m_q, leap_q);
    left        = ml - d_q;
    fits        = {11'd0, left} >= rem_q;
    same_month  = (y_q == ty_q) && (m_q == tm_q);
    end_of_year = (m_q == MonthDec);
    diff_inc    = same_month ? {1'b0, td_q - d_q} : ({1'b0, left} + 6'd1);
    diff_nxt    = diff_q + {11'd0, diff_inc};
  end

  always_comb begin
    sts_o.mode          = mode_q;
    sts_o.start_ok      = date_ok(y_q, m_q, d_q, leap_q);
    sts_o.target_ok     = date_ok(ty_q, tm_q, td_q, tleap_q);
    sts_o.cnt_ok        = 32'(rem_q) <= MaxDays;
    sts_o.target_before = {ty_q, tm_q, td_q} < {y_q, m_q, d_q};
    sts_o.step_done     = (mode_q == REQ_DIFF) ? same_month : fits;
    sts_o.step_wrap     = !sts_o.step_done && end_of_year;
    sts_o.step_err      = (mode_q == REQ_DIFF) ? (diff_nxt > DiffLimit)
                                               : (!fits && end_of_year && (y_q >= YearMax));
    sts_o.out_busy      = out_valid_q && !out_ready_i;
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= req_e'(in_user_i);
      y_q    <= in_data_i[13:0];
      m_q    <= in_data_i[17:14];
      d_q    <= in_data_i[22:18];
      rem_q  <= in_data_i[38:23];
      ty_q   <= in_data_i[52:39];
      tm_q   <= in_data_i[56:53];
      td_q   <= in_data_i[61:57];
      diff_q <= '0;
    end else if (cmd_i.step) begin
      if (mode_q == REQ_DIFF) begin
        diff_q <= diff_nxt;
      end
      if (sts_o.step_done) begin
        if (mode_q == REQ_ADD) d_q <= d_q + rem_q[4:0];
      end else begin
        rem_q <= rem_q - {11'd0, left} - 16'd1;
        d_q   <= 5'd1;
        if (end_of_year) begin
          m_q <= MonthJan;
          y_q <= y_q + 14'd1;
        end else begin
          m_q <= m_q + 4'd1;
        end
      end
    end
    if (cmd_i.leap_start) sleap_q <= leap_w;
    if (cmd_i.leap_start || cmd_i.leap_cur) leap_q <= leap_w;
    if (cmd_i.leap_target) tleap_q <= leap_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_OK;
    end else if (cmd_i.load) begin
      status_q <= ST_OK;
    end else if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
  end

  // Result register: hold until the downstream side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [13:0] res_year;
  logic [3:0]  res_month;
  logic [4:0]  res_day;
  logic [15:0] res_diff;

  // Zero the date and difference on any error, and the fields the mode does not produce
  always_comb begin
    res_year  = '0;
    res_month = '0;
    res_day   = '0;
    res_diff  = '0;
    if (status_q == ST_OK) begin
      if (mode_q == REQ_ADD) begin
        res_year  = y_q;
        res_month = m_q;
        res_day   = d_q;
      end else begin
        res_diff  = diff_q[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {sleap_q, res_diff, res_day, res_month, res_year};
      out_user_q <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

// File: tb/sv/date_add_and_difference_core_tb.sv
// Self-checking testbench for date_add_and_difference_core: directed table, then random
// add and difference requests checked against a calendar predictor, with random stalls.
// Depends on dac_pkg and the RTL of the core.
`timescale 1ns / 100ps

module date_add_and_difference_core_tb;
  import dac_pkg::*;

  localparam int     HoldOff  = 400;   // long receiver stall, in cycles
  localparam int     NRandom  = 75;
  localparam longint DiffCap  = (MaxDays < 65535) ? MaxDays : 65535;

  typedef struct packed {
    req_e        mode;
    logic [13:0] sy;
    logic [3:0]  sm;
    logic [4:0]  sd;
    logic [15:0] cnt;
    logic [13:0] ty;
    logic [3:0]  tm;
    logic [4:0]  td;
  } date_req_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] diff;
    logic        leap;
    status_e     status;
  } date_res_t;

  // One directed request; the typed result is used only where known is set.
  typedef struct {
    req_e    mode;
    int      sy, sm, sd, cnt, ty, tm, td;
    bit      known;
    int      oy, om, od, df, lp;
    status_e st;
  } dir_row_t;

  localparam int NDir = 25;
  dir_row_t dir_tab [NDir] = '{
    // mode      sy    sm  sd    cnt     ty  tm  td  k    oy  om  od   df lp status
    '{REQ_ADD,   2000,  1,  1,     0,     0,  0,  0, 1, 2000,  1,  1,   0, 1, ST_OK   },
    '{REQ_ADD,   2000,  2, 28,     1,     0,  0,  0, 0,    0,  0,  0,   0, 0, ST_OK   },
    '{REQ_ADD,   1900,  2, 28,     1,     0,  0,  0, 0,    0,  0,  0,   0, 0, ST_OK   },
    '{REQ_ADD,   2396,  2, 28,     1,     0,  0,  0, 0,    0,  0,  0,   0, 0, ST_OK   },
    '{REQ_ADD,   2024,  1, 31,    29, 16383, 15, 31, 0,    0,  0,  0,   0, 0, ST_OK   },
    '{REQ_ADD,   2023, 12, 31,     1,     0,  0,  0, 0,    0,  0,  0,   0, 0, ST_OK   },
    '{REQ_ADD,      0,  1,  1, 65535,     0,  0,  0, 0,    0,  0,  0,   0, 0, ST_OK   },
    '{REQ_ADD,   9999, 12, 31,     0,     0,  0,  0, 1, 9999, 12, 31,   0, 0, ST_OK   },
    '{REQ_ADD,   9999, 12, 31,     1,     0,  0,  0, 1,    0,  0,  0,   0, 0, ST_RANGE},
    '{REQ_ADD,   9999,  6, 15, 65535,     0,  0,  0, 1,    0,  0,  0,   0, 0, ST_RANGE},
    '{REQ_ADD,  16383, 15, 31, 65535,     0,  0,  0, 1,    0,  0,  0,   0, 0, ST_RANGE},
    '{REQ_ADD,  10000,  1,  1,     0,     0,  0,  0, 1,    0,  0,  0,   0, 1, ST_RANGE},
    '{REQ_ADD,   2024,  0, 10,     5,     0,  0,  0, 1,    0,  0,  0,   0, 1, ST_RANGE},
    '{REQ_ADD,   2024, 13, 10,     5,     0,  0,  0, 1,    0,  0,  0,   0, 1, ST_RANGE},
    '{REQ_ADD,   2021,  5,  0,     5,     0,  0,  0, 1,    0,  0,  0,   0, 0, ST_RANGE},
    '{REQ_ADD,   2023,  2, 29,     0,     0,  0,  0, 1,    0,  0,  0,   0, 0, ST_RANGE},
    '{REQ_ADD,   2023,  4, 31,     0,     0,  0,  0, 1,    0,  0,  0,   0, 0, ST_RANGE},
    '{REQ_DIFF,  2024,  3,  1, 65535,  2024,  3,  1, 1,    0,  0,  0,   0, 1, ST_OK   },
    '{REQ_DIFF,  2023,  2, 28,     0,  2024,  2, 29, 0,    0,  0,  0,   0, 0, ST_OK   },
    '{REQ_DIFF,  1900,  1,  1,     0,  2079,  6,  6, 0,    0,  0,  0,   0, 0, ST_OK   },
    '{REQ_DIFF,  1900,  1,  1,     0,  2079,  6,  7, 1,    0,  0,  0,   0, 0, ST_RANGE},
    '{REQ_DIFF,     0,  1,  1,     0,  9999, 12, 31, 1,    0,  0,  0,   0, 1, ST_RANGE},
    '{REQ_DIFF,  2000,  1,  1,     0,  1999, 12, 31, 1,    0,  0,  0,   0, 1, ST_ORDER},
    '{REQ_DIFF,  2000,  1,  0,     0,  1999,  1,  1, 1,    0,  0,  0,   0, 1, ST_RANGE},
    '{REQ_DIFF, 16383, 15, 31, 65535, 16383, 15, 31, 1,    0,  0,  0,   0, 0, ST_RANGE}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]   m_axis_tuser;

  date_res_t pending_results [$];
  int        fails;
  int        results_seen;
  int        n_add, n_diff, n_order, n_range;
  bit        steady;         // no new random idling on either side while set

  date_add_and_difference_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- calendar
  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int y, int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit real_date(int y, int m, int d);
    return (y <= 9999) && (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_days(y, m));
  endfunction

  // Days since a fixed epoch: whole years, then whole months, then the day.
  function automatic longint day_number(int y, int m, int d);
    longint n;
    n = 365 * longint'(y) + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int k = 1; k < m; k++) n += month_days(y, k);
    return n + d;
  endfunction

  function automatic date_res_t calc_date_result(date_req_t r);
    date_res_t res;
    int        y, m, d, left, room;
    longint    a, b;
    res        = '0;
    res.leap   = leap_year(int'(r.sy));
    res.status = ST_OK;
    if (!real_date(int'(r.sy), int'(r.sm), int'(r.sd))) begin
      res.status = ST_RANGE;
    end else if (r.mode == REQ_ADD) begin
      y = int'(r.sy); m = int'(r.sm); d = int'(r.sd); left = int'(r.cnt);
      if (longint'(r.cnt) > longint'(MaxDays)) begin
        res.status = ST_RANGE;
      end else begin
        // walk whole months, then land inside the last one
        while (left > 0 && y <= 9999) begin
          room = month_days(y, m) - d;
          if (left <= room) begin
            d += left;
            left = 0;
          end else begin
            left -= room + 1;
            d = 1;
            if (m == 12) begin
              m = 1;
              y++;
            end else begin
              m++;
            end
          end
        end
        if (y > 9999) begin
          res.status = ST_RANGE;
        end else begin
          res.year  = 14'(y);
          res.month = 4'(m);
          res.day   = 5'(d);
        end
      end
    end else if (!real_date(int'(r.ty), int'(r.tm), int'(r.td))) begin
      res.status = ST_RANGE;
    end else begin
      a = day_number(int'(r.sy), int'(r.sm), int'(r.sd));
      b = day_number(int'(r.ty), int'(r.tm), int'(r.td));
      if (b < a)                res.status = ST_ORDER;
      else if (b - a > DiffCap) res.status = ST_RANGE;
      else                      res.diff   = 16'(b - a);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void pick_date(output logic [13:0] y, output logic [3:0] m,
                                    output logic [4:0] d);
    int yy, r;
    int corner [10] = '{0, 1, 4, 100, 400, 1900, 2000, 2100, 9998, 9999};
    yy = (($urandom_range(0, 99) < 20) ? corner[$urandom_range(0, 9)]
                                       : $urandom_range(0, 9999));
    y  = 14'(yy);
    m  = 4'($urandom_range(1, 12));
    r  = $urandom_range(0, 99);
    if (r < 20)      d = 5'(month_days(yy, int'(m)));
    else if (r < 30) d = 5'd1;
    else             d = 5'($urandom_range(1, month_days(yy, int'(m))));
  endfunction

  function automatic date_req_t make_request();
    date_req_t r;
    int        kind, sel, ty;
    kind = $urandom_range(0, 99);
    r.ty = 14'($urandom_range(0, 16383));
    r.tm = 4'($urandom_range(0, 15));
    r.td = 5'($urandom_range(0, 31));
    r.cnt = 16'($urandom_range(0, 65535));
    pick_date(r.sy, r.sm, r.sd);
    if (kind < 45) begin
      r.mode = REQ_ADD;
      sel = $urandom_range(0, 99);
      if (sel < 50)      r.cnt = 16'($urandom_range(0, 400));
      else if (sel < 70) r.cnt = 16'($urandom_range(0, 3));
      else if (sel < 90) r.cnt = 16'($urandom_range(0, 65535));
      else               r.cnt = 16'($urandom_range(60000, 65535));
    end else if (kind < 85) begin
      r.mode = REQ_DIFF;
      if ($urandom_range(0, 9) == 0) begin
        r.ty = r.sy; r.tm = r.sm; r.td = r.sd;
      end else begin
        // mostly later, sometimes a little earlier, sometimes beyond the limit
        ty   = int'(r.sy) + $urandom_range(0, 203) - 3;
        ty   = (ty < 0) ? 0 : ((ty > 9999) ? 9999 : ty);
        r.ty = 14'(ty);
        r.tm = 4'($urandom_range(1, 12));
        r.td = 5'($urandom_range(1, month_days(ty, int'(r.tm))));
      end
    end else begin
      // raw noise on every field
      r.mode = req_e'($urandom_range(0, 1));
      r.sy   = 14'($urandom_range(0, 16383));
      r.sm   = 4'($urandom_range(0, 15));
      r.sd   = 5'($urandom_range(0, 31));
    end
    return r;
  endfunction

  // Offer one request and wait for it to be taken; called and returning at a falling edge.
  task automatic offer(input date_req_t r, input bit known, input date_res_t typed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {2'b00, r.td, r.tm, r.ty, r.cnt, r.sd, r.sm, r.sy};
    s_axis_tuser  <= r.mode;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(known ? typed : calc_date_result(r));
    if (r.mode == REQ_ADD) n_add++;
    else                   n_diff++;
    if (pending_results[$].status == ST_ORDER) n_order++;
    if (pending_results[$].status == ST_RANGE) n_range++;
    @(negedge clk_i);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : source
    date_req_t req;
    date_res_t typed;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    fails         = 0;
    n_add = 0; n_diff = 0; n_order = 0; n_range = 0;
    steady        = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      req.mode = dir_tab[i].mode;
      req.sy   = 14'(dir_tab[i].sy);
      req.sm   = 4'(dir_tab[i].sm);
      req.sd   = 5'(dir_tab[i].sd);
      req.cnt  = 16'(dir_tab[i].cnt);
      req.ty   = 14'(dir_tab[i].ty);
      req.tm   = 4'(dir_tab[i].tm);
      req.td   = 5'(dir_tab[i].td);
      typed.year   = 14'(dir_tab[i].oy);
      typed.month  = 4'(dir_tab[i].om);
      typed.day    = 5'(dir_tab[i].od);
      typed.diff   = 16'(dir_tab[i].df);
      typed.leap   = dir_tab[i].lp[0];
      typed.status = dir_tab[i].st;
      offer(req, dir_tab[i].known, typed);
    end
    drain();

    typed = '0;
    for (int n = 0; n < NRandom; n++) begin
      steady = (n >= 40 && n < 60);
      if (n == 70) drain();
      offer(make_request(), 1'b0, typed);
    end
    steady = 1'b0;
    drain();
    repeat (100) @(posedge clk_i);

    $display("Checked %0d results: %0d add and %0d difference requests.",
             results_seen, n_add, n_diff);
    $display("Error results: %0d target before start, %0d out of range.", n_order, n_range);
    if (fails == 0) begin
      $display("** date_add_and_difference_core: PASSED **");
    end else begin
      $display("** date_add_and_difference_core: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  initial begin : sink
    int  stall;
    bit  held;
    m_axis_tready = 1'b0;
    stall         = 0;
    held          = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      // one long hold-off so the core backs up into its input
      if (!held && results_seen >= 50) begin
        held  = 1'b1;
        stall = HoldOff;
      end
      if (stall == 0 && !steady && $urandom_range(0, 99) < 20) stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checking
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    date_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %0d",
               m_axis_tdata, m_axis_tuser);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_year",       16'(want.year),   16'(m_axis_tdata[13:0]));
        check_field("out_month",      16'(want.month),  16'(m_axis_tdata[17:14]));
        check_field("out_day",        16'(want.day),    16'(m_axis_tdata[22:18]));
        check_field("day_difference", want.diff,        m_axis_tdata[38:23]);
        check_field("start_is_leap",  16'(want.leap),   16'(m_axis_tdata[39]));
        check_field("status",         16'(want.status), 16'(m_axis_tuser));
      end
    end
  end

  initial results_seen = 0;

  initial begin : watchdog
    #4000000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("** date_add_and_difference_core: FAILED **");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/dac_pkg.sv
hw/rtl/dac_ctrl.sv
hw/rtl/dac_dpath.sv
hw/rtl/date_add_and_difference_core.sv
tb/sv/date_add_and_difference_core_tb.sv
